FILE: rtl/scs_pkg.sv
// scs_pkg: shared types, widths and constants for the sensor calibration
// and smoothing block. No dependencies; every rtl file imports it.

package scs_pkg;

  // Block configuration
  localparam int WINDOW    = 5;
  localparam int FRAC_BITS = 6;

  // Port field widths
  localparam int RAW_W      = 16;
  localparam int TREF_W     = 10;
  localparam int HREF_W     = 8;
  localparam int TAVG_W     = 20;
  localparam int HAVG_W     = 13;
  localparam int ERR_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_REF_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_REF_HIGH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_RAW_LOW  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_RAW_HIGH = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_HUM_REF_LOW   = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_HUM_REF_HIGH  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_HUM_RAW_LOW   = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_HUM_RAW_HIGH  = CFG_IDX_W'(7);

  // Calibration arithmetic
  localparam int DIFF_W  = RAW_W + 1;          // raw difference, signed
  localparam int TSPAN_W = TREF_W + 1;         // reference span, signed
  localparam int HSPAN_W = HREF_W + 1;
  localparam int TPROD_W = DIFF_W + TSPAN_W;   // difference times span
  localparam int HPROD_W = DIFF_W + HSPAN_W;
  localparam int TSHIFT  = FRAC_BITS - 3;      // eighths of a degree to 2^-F
  localparam int HSHIFT  = FRAC_BITS - 1;      // half percent to 2^-F
  localparam int TNUM_W  = TPROD_W + TSHIFT;
  localparam int HNUM_W  = HPROD_W + HSHIFT;
  localparam int DIV_W   = (TNUM_W > HNUM_W) ? TNUM_W : HNUM_W;
  localparam int DEN_W   = RAW_W;              // magnitude of a raw difference
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int QS_W    = DIV_W + 1;          // signed quotient
  localparam int CAL_W   = DIV_W + 2;          // base plus signed quotient
  localparam int TBASE_W = TREF_W + TSHIFT;
  localparam int HBASE_W = HREF_W + HSHIFT;

  localparam logic signed [CAL_W-1:0] TEMP_MAX_C = CAL_W'((64'd1 << (TAVG_W - 1)) - 64'd1);
  localparam logic signed [CAL_W-1:0] TEMP_MIN_C = ~TEMP_MAX_C;
  localparam logic signed [CAL_W-1:0] HUM_MAX_C  = CAL_W'(64'd100 << FRAC_BITS);

  // Moving average
  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int TSUM_W  = TAVG_W + SLOT_W;
  localparam int HSUM_W  = HAVG_W + SLOT_W;
  // window sum divided by WINDOW via exact reciprocal multiply
  localparam int AVG_N   = TSUM_W;
  localparam int AVG_K   = AVG_N + SLOT_W;
  localparam int AVG_M_W = AVG_N + 1;
  localparam int AVG_P_W = AVG_N + AVG_M_W;
  localparam int AVG_Q_W = AVG_P_W - AVG_K;
  localparam logic [63:0] AVG_M_FULL =
    ((64'd1 << AVG_K) + 64'(WINDOW - 1)) / 64'(WINDOW);
  localparam logic [AVG_M_W-1:0] AVG_M = AVG_M_FULL[AVG_M_W-1:0];

  // Channel payloads
  typedef struct packed {
    logic signed [RAW_W-1:0] temp_sample;
    logic signed [RAW_W-1:0] hum_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [TAVG_W-1:0] temperature_avg;
    logic        [HAVG_W-1:0] humidity_avg;
    logic        [ERR_W-1:0]  calib_error;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture sample differences
    logic mult;       // difference times span
    logic prefill;    // fill both windows with the lower reference
    logic div_start;  // launch both dividers
    logic calib;      // add base, saturate / clamp
    logic update;     // write window slot, update running sums
    logic avg_mul;    // reciprocal multiply of the sums
    logic out_load;   // load the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

FILE: rtl/scs_div.sv
// scs_div: iterative restoring divider for unsigned magnitudes, one
// quotient bit per cycle. Depends on scs_pkg.

module scs_div
  import scs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     dvs_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             fits;
  logic [DEN_W-1:0] rem_nxt;
  logic [DIV_W-1:0] quo_nxt;
  logic             last;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    fits    = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    quo_nxt = {quo_r[DIV_W-2:0], fits};
    last    = (cnt_r == DIV_CNT_W'(DIV_W - 1));
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses for one cycle after the final step
      done_r <= !start && busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/scs_datapath.sv
// scs_datapath: configuration registers, calibration arithmetic, the two
// dividers, smoothing windows and the output register. Depends on scs_pkg
// and scs_div.

module scs_datapath
  import scs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_item_t              in_data,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  output out_item_t             out_data
);

  // Configuration registers
  logic        [TREF_W-1:0] t_lo_r, t_hi_r;
  logic signed [RAW_W-1:0]  tr_lo_r, tr_hi_r;
  logic        [HREF_W-1:0] h_lo_r, h_hi_r;
  logic signed [RAW_W-1:0]  hr_lo_r, hr_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_lo_r  <= '0;
      t_hi_r  <= '0;
      tr_lo_r <= '0;
      tr_hi_r <= '0;
      h_lo_r  <= '0;
      h_hi_r  <= '0;
      hr_lo_r <= '0;
      hr_hi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TEMP_REF_LOW:  t_lo_r  <= cfg_wdata[TREF_W-1:0];
        REG_TEMP_REF_HIGH: t_hi_r  <= cfg_wdata[TREF_W-1:0];
        REG_TEMP_RAW_LOW:  tr_lo_r <= cfg_wdata[RAW_W-1:0];
        REG_TEMP_RAW_HIGH: tr_hi_r <= cfg_wdata[RAW_W-1:0];
        REG_HUM_REF_LOW:   h_lo_r  <= cfg_wdata[HREF_W-1:0];
        REG_HUM_REF_HIGH:  h_hi_r  <= cfg_wdata[HREF_W-1:0];
        REG_HUM_RAW_LOW:   hr_lo_r <= cfg_wdata[RAW_W-1:0];
        REG_HUM_RAW_HIGH:  hr_hi_r <= cfg_wdata[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  // Terms derived from configuration
  logic signed [DIFF_W-1:0]  t_den, h_den;
  logic signed [TSPAN_W-1:0] t_span;
  logic signed [HSPAN_W-1:0] h_span;
  logic        [TBASE_W-1:0] t_base;
  logic        [HBASE_W-1:0] h_base;
  logic                      t_err, h_err;

  always_comb begin
    t_den  = {tr_hi_r[RAW_W-1], tr_hi_r} - {tr_lo_r[RAW_W-1], tr_lo_r};
    h_den  = {hr_hi_r[RAW_W-1], hr_hi_r} - {hr_lo_r[RAW_W-1], hr_lo_r};
    t_span = {1'b0, t_hi_r} - {1'b0, t_lo_r};
    h_span = {1'b0, h_hi_r} - {1'b0, h_lo_r};
    t_base = TBASE_W'(t_lo_r) << TSHIFT;
    h_base = HBASE_W'(h_lo_r) << HSHIFT;
    t_err  = (t_den == '0);
    h_err  = (h_den == '0);
  end

  // Sample difference and product registers
  logic signed [DIFF_W-1:0]  t_diff_r, h_diff_r;
  logic signed [TPROD_W-1:0] t_prod_r;
  logic signed [HPROD_W-1:0] h_prod_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_diff_r <= {in_data.temp_sample[RAW_W-1], in_data.temp_sample}
                  - {tr_lo_r[RAW_W-1], tr_lo_r};
      h_diff_r <= {in_data.hum_sample[RAW_W-1], in_data.hum_sample}
                  - {hr_lo_r[RAW_W-1], hr_lo_r};
    end
    if (cmd.mult) begin
      t_prod_r <= t_diff_r * t_span;
      h_prod_r <= h_diff_r * h_span;
    end
  end

  // Divider operands: magnitudes, sign kept aside
  logic [TPROD_W-1:0] t_prod_abs;
  logic [HPROD_W-1:0] h_prod_abs;
  logic [DIFF_W-1:0]  t_den_abs, h_den_abs;
  logic [DIV_W-1:0]   t_dvd, h_dvd;
  logic [DIV_W-1:0]   t_quo, h_quo;
  logic               t_done, h_done;
  logic               t_qneg_r, h_qneg_r;

  always_comb begin
    t_prod_abs = t_prod_r[TPROD_W-1] ? TPROD_W'(-t_prod_r) : TPROD_W'(t_prod_r);
    h_prod_abs = h_prod_r[HPROD_W-1] ? HPROD_W'(-h_prod_r) : HPROD_W'(h_prod_r);
    t_den_abs  = t_den[DIFF_W-1] ? DIFF_W'(-t_den) : DIFF_W'(t_den);
    h_den_abs  = h_den[DIFF_W-1] ? DIFF_W'(-h_den) : DIFF_W'(h_den);
    t_dvd      = DIV_W'(t_prod_abs) << TSHIFT;
    h_dvd      = DIV_W'(h_prod_abs) << HSHIFT;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      t_qneg_r <= t_prod_r[TPROD_W-1] ^ t_den[DIFF_W-1];
      h_qneg_r <= h_prod_r[HPROD_W-1] ^ h_den[DIFF_W-1];
    end
  end

  scs_div u_tdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (t_dvd),
    .divisor  (t_den_abs[DEN_W-1:0]),
    .done     (t_done),
    .quotient (t_quo)
  );

  scs_div u_hdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (h_dvd),
    .divisor  (h_den_abs[DEN_W-1:0]),
    .done     (h_done),
    .quotient (h_quo)
  );

  assign sts.div_done = t_done & h_done;

  // Calibrated value: base plus truncated quotient (base alone on a zero denominator), then range limits
  logic signed [QS_W-1:0]   t_qs, h_qs;
  logic signed [CAL_W-1:0]  t_sel, h_sel;
  logic signed [TAVG_W-1:0] t_lim;
  logic        [HAVG_W-1:0] h_lim;
  logic signed [TAVG_W-1:0] t_val_r;
  logic        [HAVG_W-1:0] h_val_r;
  logic        [ERR_W-1:0]  err_r;

  always_comb begin
    t_qs = t_qneg_r ? -$signed({1'b0, t_quo}) : $signed({1'b0, t_quo});
    h_qs = h_qneg_r ? -$signed({1'b0, h_quo}) : $signed({1'b0, h_quo});
    if (t_err) begin
      t_sel = $signed(CAL_W'(t_base));
    end else begin
      t_sel = $signed(CAL_W'(t_base)) + {t_qs[QS_W-1], t_qs};
    end
    if (h_err) begin
      h_sel = $signed(CAL_W'(h_base));
    end else begin
      h_sel = $signed(CAL_W'(h_base)) + {h_qs[QS_W-1], h_qs};
    end
    // temperature saturates to the output range
    if (t_sel > TEMP_MAX_C) begin
      t_lim = TEMP_MAX_C[TAVG_W-1:0];
    end else if (t_sel < TEMP_MIN_C) begin
      t_lim = TEMP_MIN_C[TAVG_W-1:0];
    end else begin
      t_lim = t_sel[TAVG_W-1:0];
    end
    // humidity clamps to 0..100 %
    if (h_sel[CAL_W-1]) begin
      h_lim = '0;
    end else if (h_sel > HUM_MAX_C) begin
      h_lim = HUM_MAX_C[HAVG_W-1:0];
    end else begin
      h_lim = h_sel[HAVG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calib) begin
      t_val_r <= t_lim;
      h_val_r <= h_lim;
      err_r   <= {h_err, t_err};
    end
  end

  // Smoothing windows with running sums
  logic signed [TAVG_W-1:0] t_win_r [WINDOW];
  logic        [HAVG_W-1:0] h_win_r [WINDOW];
  logic signed [TSUM_W-1:0] t_sum_r;
  logic        [HSUM_W-1:0] h_sum_r;
  logic        [SLOT_W-1:0] slot_r;
  logic signed [TAVG_W-1:0] t_old;
  logic        [HAVG_W-1:0] h_old;

  assign t_old = t_win_r[slot_r];
  assign h_old = h_win_r[slot_r];

  always_ff @(posedge clk) begin
    if (cmd.prefill) begin
      for (int i = 0; i < WINDOW; i++) begin
        t_win_r[i] <= TAVG_W'(t_base);
        h_win_r[i] <= HAVG_W'(h_base);
      end
      t_sum_r <= TSUM_W'(t_base) * TSUM_W'(WINDOW);
      h_sum_r <= HSUM_W'(h_base) * HSUM_W'(WINDOW);
    end else if (cmd.update) begin
      t_win_r[slot_r] <= t_val_r;
      h_win_r[slot_r] <= h_val_r;
      t_sum_r <= t_sum_r - {{SLOT_W{t_old[TAVG_W-1]}}, t_old}
                 + {{SLOT_W{t_val_r[TAVG_W-1]}}, t_val_r};
      h_sum_r <= h_sum_r - HSUM_W'(h_old) + HSUM_W'(h_val_r);
    end
  end

  // Write slot, shared by both channels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (cmd.update) begin
      slot_r <= (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
    end
  end

  // Sum / WINDOW: reciprocal multiply on magnitudes
  logic [AVG_N-1:0]   t_sum_abs;
  logic [AVG_P_W-1:0] t_avg_p_r, h_avg_p_r;
  logic               t_avg_neg_r;

  assign t_sum_abs = t_sum_r[TSUM_W-1] ? AVG_N'(-t_sum_r) : AVG_N'(t_sum_r);

  always_ff @(posedge clk) begin
    if (cmd.avg_mul) begin
      t_avg_p_r   <= AVG_P_W'(t_sum_abs) * AVG_P_W'(AVG_M);
      h_avg_p_r   <= AVG_P_W'(h_sum_r) * AVG_P_W'(AVG_M);
      t_avg_neg_r <= t_sum_r[TSUM_W-1];
    end
  end

  // Output register
  logic [AVG_Q_W-1:0] t_avg_q, h_avg_q, t_avg_s;
  out_item_t          out_r;

  always_comb begin
    t_avg_q = t_avg_p_r[AVG_P_W-1:AVG_K];
    h_avg_q = h_avg_p_r[AVG_P_W-1:AVG_K];
    t_avg_s = t_avg_neg_r ? -t_avg_q : t_avg_q;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.temperature_avg <= t_avg_s[TAVG_W-1:0];
      out_r.humidity_avg    <= h_avg_q[HAVG_W-1:0];
      out_r.calib_error     <= err_r;
    end
  end

  assign out_data = out_r;

endmodule

FILE: rtl/scs_ctrl.sv
// scs_ctrl: controller for the calibration and smoothing datapath;
// sequences one item at a time and owns the handshakes. Depends on scs_pkg.

module scs_ctrl
  import scs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cfg_we,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULT,
    S_DIVS,
    S_DIVW,
    S_CALIB,
    S_UPDT,
    S_AVGM,
    S_OUTP
  } state_t;

  state_t state_r, state_nxt;
  logic   primed_r, primed_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    primed_nxt = primed_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MULT;
        end
      end
      S_MULT: begin
        cmd.mult    = 1'b1;
        cmd.prefill = !primed_r;
        primed_nxt  = 1'b1;
        state_nxt   = S_DIVS;
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          state_nxt = S_CALIB;
        end
      end
      S_CALIB: begin
        cmd.calib = 1'b1;
        state_nxt = S_UPDT;
      end
      S_UPDT: begin
        cmd.update = 1'b1;
        state_nxt  = S_AVGM;
      end
      S_AVGM: begin
        cmd.avg_mul = 1'b1;
        state_nxt   = S_OUTP;
      end
      S_OUTP: begin
        // wait until the output register is free or being emptied
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // any register write forces a window prefill on the next item
    if (cfg_we) begin
      primed_nxt = 1'b0;
    end
  end

  // Output valid tracking
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      primed_r    <= primed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/sensor_calib_smoothing_unit.sv
// sensor_calib_smoothing_unit: top level of the temperature / humidity
// calibration and smoothing block. Depends on scs_pkg, scs_ctrl, scs_datapath.
//
// Usage:
//   Input channel (in_valid / in_ready / in_data) carries one raw temperature
//   and one raw humidity sample per item. Result channel (out_valid /
//   out_ready / out_data) returns one item per input: both smoothed values
//   with 6 fraction bits and the two calibration error flags.
//   Configuration is a plain write port (cfg_we, cfg_idx, cfg_wdata); write
//   only while no item is in flight. A write makes the next item refill both
//   5-sample windows with the lower reference values.
//   Sequencing: an accept is followed by the multiply, divider start and
//   wait, calibrate, window update, reciprocal multiply and output load
//   states; in_ready returns with out_valid, so items never overlap. Both
//   31-step dividers run in parallel, one quotient bit per cycle.
//   A finished result sits in the output register; the next item is
//   accepted while it waits. If the receiver still stalls when the following
//   result is ready, the controller holds that result and in_ready stays low.
//   Reset (rst_n, synchronous, active low) clears the configuration to zero,
//   the write slot, the output valid and forces a prefill on the first item.

module sensor_calib_smoothing_unit
  import scs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  scs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (dp_cmd),
    .sts       (dp_sts)
  );

  scs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_data  (out_data)
  );

  // One item in flight: an accept closes the input until the item is done
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // A new result never overwrites one the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten before it was taken");

  // Calibration only uses a finished quotient
  a_div_complete: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.calib |-> $past(dp_sts.div_done))
    else $error("calibration step without a completed division");

endmodule

FILE: bench/tb_sensor_calib_smoothing_unit.sv
// tb_sensor_calib_smoothing_unit: self-checking bench for the temperature /
// humidity calibration and smoothing block. Depends on scs_pkg and the rtl
// top sensor_calib_smoothing_unit; predicts every item and checks each result.
`timescale 1ns / 100ps

module tb_sensor_calib_smoothing_unit;
  import scs_pkg::*;

  localparam int  LIMIT   = 300000;
  localparam int  TSCALE  = 1 << (FRAC_BITS - 3);
  localparam int  HSCALE  = 1 << (FRAC_BITS - 1);
  localparam longint T_SAT_HI = (64'sd1 <<< (TAVG_W - 1)) - 1;
  localparam longint T_SAT_LO = -(64'sd1 <<< (TAVG_W - 1));
  localparam longint H_CLAMP  = 64'sd100 <<< FRAC_BITS;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;

  sensor_calib_smoothing_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Calibration registers as the block should hold them
  logic        [TREF_W-1:0] cal_t_lo, cal_t_hi;
  logic signed [RAW_W-1:0]  cal_tr_lo, cal_tr_hi;
  logic        [HREF_W-1:0] cal_h_lo, cal_h_hi;
  logic signed [RAW_W-1:0]  cal_hr_lo, cal_hr_hi;

  // Smoothing state
  longint temp_ring [WINDOW];
  longint hum_ring  [WINDOW];
  int     ring_slot;
  bit     ring_primed;

  out_item_t pending_readings [$];
  int        err_count;
  int        cycle_count;
  bit        tx_idle, rx_idle;
  int        hold_request;

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Expected result for one accepted item; advances the smoothing state
  function automatic out_item_t calibrate_and_smooth(in_item_t it);
    longint t, h, tbase, hbase, tden, hden, tv, hv, tsum, hsum, r0, span;
    bit terr, herr;
    out_item_t r;
    t     = it.temp_sample;
    h     = it.hum_sample;
    tbase = longint'(cal_t_lo) * TSCALE;
    hbase = longint'(cal_h_lo) * HSCALE;
    if (!ring_primed) begin
      for (int i = 0; i < WINDOW; i++) begin
        temp_ring[i] = tbase;
        hum_ring[i]  = hbase;
      end
      ring_primed = 1'b1;
    end
    // temperature: two-point line, saturate to the output width
    r0   = cal_tr_lo;
    tden = longint'(cal_tr_hi) - r0;
    span = longint'(cal_t_hi) - longint'(cal_t_lo);
    terr = (tden == 0);
    if (terr) tv = tbase;
    else tv = tbase + ((t - r0) * span * TSCALE) / tden;
    if (tv > T_SAT_HI) tv = T_SAT_HI;
    if (tv < T_SAT_LO) tv = T_SAT_LO;
    // humidity: two-point line, clamp to 0..100 %
    r0   = cal_hr_lo;
    hden = longint'(cal_hr_hi) - r0;
    span = longint'(cal_h_hi) - longint'(cal_h_lo);
    herr = (hden == 0);
    if (herr) hv = hbase;
    else hv = hbase + ((h - r0) * span * HSCALE) / hden;
    if (hv < 0) hv = 0;
    if (hv > H_CLAMP) hv = H_CLAMP;
    temp_ring[ring_slot] = tv;
    hum_ring[ring_slot]  = hv;
    ring_slot = (ring_slot + 1) % WINDOW;
    tsum = 0;
    hsum = 0;
    for (int i = 0; i < WINDOW; i++) begin
      tsum += temp_ring[i];
      hsum += hum_ring[i];
    end
    r.temperature_avg = TAVG_W'(tsum / WINDOW);
    r.humidity_avg    = HAVG_W'(hsum / WINDOW);
    r.calib_error     = {herr, terr};
    return r;
  endfunction

  // Offer one item, wait for the handshake, then maybe idle a burst
  task automatic send_item(logic [RAW_W-1:0] tval, logic [RAW_W-1:0] hval);
    int gap;
    @(negedge clk);
    in_valid            = 1'b1;
    in_data.temp_sample = tval;
    in_data.hum_sample  = hval;
    do @(posedge clk); while (!in_ready);
    pending_readings.push_back(calibrate_and_smooth(in_data));
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every result has been taken
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Write all eight registers while idle; the next item refills the windows
  task automatic program_calibration(
    logic [15:0] t_lo, logic [15:0] t_hi, logic [15:0] tr_lo, logic [15:0] tr_hi,
    logic [15:0] h_lo, logic [15:0] h_hi, logic [15:0] hr_lo, logic [15:0] hr_hi);
    logic [15:0] vals [8];
    logic [CFG_IDX_W-1:0] idx_list [8];
    vals     = '{t_lo, t_hi, tr_lo, tr_hi, h_lo, h_hi, hr_lo, hr_hi};
    idx_list = '{REG_TEMP_REF_LOW, REG_TEMP_REF_HIGH, REG_TEMP_RAW_LOW,
                 REG_TEMP_RAW_HIGH, REG_HUM_REF_LOW, REG_HUM_REF_HIGH,
                 REG_HUM_RAW_LOW, REG_HUM_RAW_HIGH};
    drain();
    repeat (4) @(posedge clk);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we    = 1'b1;
      cfg_idx   = idx_list[i];
      cfg_wdata = vals[i];
      @(posedge clk);
      case (idx_list[i])
        REG_TEMP_REF_LOW:  cal_t_lo  = vals[i][TREF_W-1:0];
        REG_TEMP_REF_HIGH: cal_t_hi  = vals[i][TREF_W-1:0];
        REG_TEMP_RAW_LOW:  cal_tr_lo = vals[i];
        REG_TEMP_RAW_HIGH: cal_tr_hi = vals[i];
        REG_HUM_REF_LOW:   cal_h_lo  = vals[i][HREF_W-1:0];
        REG_HUM_REF_HIGH:  cal_h_hi  = vals[i][HREF_W-1:0];
        REG_HUM_RAW_LOW:   cal_hr_lo = vals[i];
        REG_HUM_RAW_HIGH:  cal_hr_hi = vals[i];
        default: ;
      endcase
      ring_primed = 1'b0;
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Register value: often an extreme, otherwise anywhere in range
  function automatic logic [15:0] pick_reg(int bits);
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: v = (bits == RAW_W) ? 16'h8000 : 16'h0000;
      1: v = (bits == RAW_W) ? 16'h7FFF : 16'((1 << bits) - 1);
      default: v = 16'($urandom_range(0, (1 << bits) - 1));
    endcase
    return v;
  endfunction

  // Raw sample: full range, or between the two raw reference points
  function automatic logic [15:0] pick_sample(logic signed [15:0] a, logic signed [15:0] b);
    int lo, hi;
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 16'hFFFF));
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return 16'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  // Result checker
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        $error("out_data: no item expected, got %h", out_data);
        err_count++;
      end else begin
        want = pending_readings.pop_front();
        if (out_data.temperature_avg !== want.temperature_avg) begin
          $error("temperature_avg: expected %0d, got %0d",
                 want.temperature_avg, out_data.temperature_avg);
          err_count++;
        end
        if (out_data.humidity_avg !== want.humidity_avg) begin
          $error("humidity_avg: expected %0d, got %0d",
                 want.humidity_avg, out_data.humidity_avg);
          err_count++;
        end
        if (out_data.calib_error !== want.calib_error) begin
          $error("calib_error: expected %0d, got %0d",
                 want.calib_error, out_data.calib_error);
          err_count++;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off on request
  initial begin : receiver
    int stall_left, hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (rx_idle && $urandom_range(0, 5) == 0) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("tb_sensor_calib_smoothing_unit: done, errors");
      $finish;
    end
  end

  // Registers at reset are all zero: both denominators are zero
  task automatic test_reset_defaults();
    send_item(16'h7FFF, 16'h7FFF);
    send_item(16'h8000, 16'h8000);
    send_item(16'h0000, 16'h0000);
    send_item(16'hFFFF, 16'h0001);
  endtask

  // Ordinary calibration, reference points hit, humidity clamped both ways
  task automatic test_two_point_nominal();
    program_calibration(16'd200, 16'd680, -16'sd12000, 16'sd18000,
                        16'd40, 16'd180, -16'sd5000, 16'sd25000);
    send_item(-16'sd12000, -16'sd5000);
    send_item(16'sd18000, 16'sd25000);
    send_item(16'h0000, 16'h0000);
    send_item(16'h7FFF, 16'h7FFF);
    send_item(16'h8000, 16'h8000);
    send_item(16'sd1234, -16'sd4321);
  endtask

  // Steepest slopes: temperature saturates, humidity clamps
  task automatic test_saturation_clamp();
    program_calibration(16'd0, 16'd1023, 16'd0, 16'd1, 16'd0, 16'd255, 16'd0, 16'd1);
    send_item(16'h7FFF, 16'h7FFF);
    send_item(16'h8000, 16'h8000);
    send_item(16'h0001, 16'hFFFF);
    // reversed points: humidity falling, temperature still rising
    program_calibration(16'd1023, 16'd0, 16'h7FFF, 16'h8000,
                        16'd255, 16'd0, 16'h8000, 16'h7FFF);
    send_item(16'h8000, 16'h7FFF);
    send_item(16'h7FFF, 16'h8000);
  endtask

  // Equal raw points: error flags, lower reference used, prefill unclamped
  task automatic test_zero_denominator();
    program_calibration(16'd1023, 16'd5, 16'h1234, 16'h1234,
                        16'd255, 16'd0, -16'sd7, -16'sd7);
    send_item(16'h7FFF, 16'h8000);
    send_item(16'h0000, 16'h0000);
    send_item(16'h8000, 16'h7FFF);
    program_calibration(16'd1023, 16'd5, 16'h1234, 16'h1235,
                        16'd255, 16'd0, -16'sd7, -16'sd7);
    send_item(16'h1235, 16'h0000);
    send_item(16'h1233, 16'h5555);
  endtask

  // Random settings, alternating extreme-heavy and realistic ones
  task automatic test_random_settings(int phases, int items_per_phase);
    for (int p = 0; p < phases; p++) begin
      if (p % 2 == 0)
        program_calibration(pick_reg(TREF_W), pick_reg(TREF_W), pick_reg(RAW_W),
                            pick_reg(RAW_W), pick_reg(HREF_W), pick_reg(HREF_W),
                            pick_reg(RAW_W), pick_reg(RAW_W));
      else
        program_calibration(16'($urandom_range(0, 400)), 16'($urandom_range(400, 1023)),
                            16'(int'($urandom_range(0, 20000)) - 10000),
                            16'(int'($urandom_range(0, 20000)) - 10000),
                            16'($urandom_range(0, 100)), 16'($urandom_range(100, 255)),
                            16'(int'($urandom_range(0, 30000)) - 15000),
                            16'(int'($urandom_range(0, 30000)) - 15000));
      for (int i = 0; i < items_per_phase; i++)
        send_item(pick_sample(cal_tr_lo, cal_tr_hi), pick_sample(cal_hr_lo, cal_hr_hi));
    end
  endtask

  // Long receiver hold-off while items keep coming: input must stall
  task automatic test_output_backpressure();
    drain();
    tx_idle      = 1'b0;
    rx_idle      = 1'b0;
    hold_request = 600;
    for (int i = 0; i < 12; i++)
      send_item(pick_sample(cal_tr_lo, cal_tr_hi), pick_sample(cal_hr_lo, cal_hr_hi));
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Closing stretch at full rate, no idling on either side
  task automatic test_full_rate();
    program_calibration(16'd160, 16'd720, -16'sd20000, 16'sd20000,
                        16'd20, 16'd200, 16'sd1000, 16'sd31000);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int i = 0; i < 40; i++)
      send_item(pick_sample(cal_tr_lo, cal_tr_hi), pick_sample(cal_hr_lo, cal_hr_hi));
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_data      = '0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    hold_request = 0;
    err_count    = 0;
    cycle_count  = 0;
    cal_t_lo  = '0;
    cal_t_hi  = '0;
    cal_tr_lo = '0;
    cal_tr_hi = '0;
    cal_h_lo  = '0;
    cal_h_hi  = '0;
    cal_hr_lo = '0;
    cal_hr_hi = '0;
    for (int i = 0; i < WINDOW; i++) begin
      temp_ring[i] = 0;
      hum_ring[i]  = 0;
    end
    ring_slot   = 0;
    ring_primed = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_two_point_nominal();
    test_saturation_clamp();
    test_zero_denominator();
    test_random_settings(8, 55);
    test_output_backpressure();
    test_full_rate();

    drain();
    repeat (60) @(posedge clk);
    if (err_count == 0 && pending_readings.size() == 0)
      $display("tb_sensor_calib_smoothing_unit: done, clean");
    else
      $display("tb_sensor_calib_smoothing_unit: done, errors");
    $finish;
  end

endmodule
